// ===== design/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: explicit clock and active-low reset.
`define CHC_ASSERT(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
		else $error("chc assertion failed");

// Short form for modules that use clk and arst_n.
`define CHC_CHECK(lbl, prop) `CHC_ASSERT(lbl, clk, arst_n, prop)

`endif

// ===== design/chc_pkg.sv =====
package chc_pkg;

	localparam int COUNT_WIDTH  = 24;
	localparam int CHART_HEIGHT = 100;
	localparam int GRID_STEP    = 10;

	localparam int NUM_BINS     = 256;
	localparam int BIN_W        = 8;
	localparam int ROW_W        = 7;
	localparam int PIXEL_W      = 32;
	localparam int COLOR_W      = 32;
	localparam int OUT_COUNT_W  = 24;
	localparam int CMD_W        = 2;
	localparam int SEL_W        = 2;

	localparam int HGT_W  = $clog2(CHART_HEIGHT + 1);
	localparam int CMP_W  = (HGT_W > ROW_W) ? HGT_W : ROW_W;
	localparam int PROD_W = COUNT_WIDTH + CMP_W;

	typedef logic [CMD_W-1:0]       cmd_t;
	typedef logic [SEL_W-1:0]       sel_t;
	typedef logic [BIN_W-1:0]       bin_t;
	typedef logic [ROW_W-1:0]       row_t;
	typedef logic [PIXEL_W-1:0]     pixel_t;
	typedef logic [COLOR_W-1:0]     color_t;
	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [PROD_W-1:0]      prod_t;
	typedef logic [CMP_W-1:0]       hgt_t;

	localparam cmd_t CMD_CLEAR  = 2'd0;
	localparam cmd_t CMD_ACCUM  = 2'd1;
	localparam cmd_t CMD_RENDER = 2'd2;

	localparam sel_t CH_RED   = 2'd0;
	localparam sel_t CH_GREEN = 2'd1;

	localparam color_t COLOR_RED   = 32'h0000FF00;
	localparam color_t COLOR_GREEN = 32'h00FF0000;
	localparam color_t COLOR_BLUE  = 32'hFF000000;
	localparam color_t COLOR_GRID  = 32'hFFFFFF00;
	localparam color_t COLOR_BACK  = 32'hC0C0C000;

	localparam count_t COUNT_MAX = {COUNT_WIDTH{1'b1}};
	localparam hgt_t   HGT_VAL   = CMP_W'(CHART_HEIGHT);

	// Write side of the bin store: one increment or a full clear per cycle.
	typedef struct packed {
		logic   we;
		logic   clr;
		bin_t   addr;
		count_t data;
	} store_wr_t;

	function automatic bin_t channel_bin(pixel_t px, sel_t sel);
		case (sel)
			CH_RED:   return px[8 +: BIN_W];
			CH_GREEN: return px[16 +: BIN_W];
			default:  return px[24 +: BIN_W];
		endcase
	endfunction

	function automatic color_t bar_color(sel_t sel);
		case (sel)
			CH_RED:   return COLOR_RED;
			CH_GREEN: return COLOR_GREEN;
			default:  return COLOR_BLUE;
		endcase
	endfunction

	// True when the row is a multiple of the grid step.
	function automatic logic grid_row(row_t r);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k * GRID_STEP < (1 << ROW_W); k++) begin
			if (r == ROW_W'(k * GRID_STEP))
				hit = 1'b1;
		end
		return hit;
	endfunction

endpackage

// ===== design/chc_ifs.sv =====
interface chc_req_if import chc_pkg::*; ();
	logic   valid;
	logic   ready;
	cmd_t   cmd;
	pixel_t pixel_word;
	bin_t   column;
	row_t   row;

	modport source(output valid, cmd, pixel_word, column, row, input ready);
	modport sink(input valid, cmd, pixel_word, column, row, output ready);
endinterface

interface chc_rsp_if import chc_pkg::*; ();
	logic                   valid;
	logic                   ready;
	color_t                 chart_color;
	logic [OUT_COUNT_W-1:0] column_count;

	modport source(output valid, chart_color, column_count, input ready);
	modport sink(input valid, chart_color, column_count, output ready);
endinterface

interface chc_cfg_if import chc_pkg::*; ();
	logic valid;
	logic ready;
	sel_t channel_select;

	modport source(output valid, channel_select, input ready);
	modport sink(input valid, channel_select, output ready);
endinterface

// ===== design/chc_bin_store.sv =====
module chc_bin_store import chc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      rd_en,
	input  bin_t      rd_addr,
	input  store_wr_t wr,
	output count_t    rd_data
);

	count_t             mem [NUM_BINS];
	logic [NUM_BINS-1:0] vld_q;

	count_t mem_rd_q;
	count_t fwd_q;
	logic   vld_rd_q;
	logic   fwd_hit_q;

	always_ff @(posedge clk) begin
		if (wr.we)
			mem[wr.addr] <= wr.data;
		if (rd_en) begin
			mem_rd_q <= mem[rd_addr];
			// bypass a write or clear landing on the same edge as the read
			fwd_q    <= wr.clr ? '0 : wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			vld_rd_q  <= 1'b0;
			fwd_hit_q <= 1'b0;
		end else begin
			if (wr.clr)
				vld_q <= '0;
			else if (wr.we)
				vld_q[wr.addr] <= 1'b1;
			if (rd_en) begin
				vld_rd_q  <= vld_q[rd_addr];
				fwd_hit_q <= wr.clr || (wr.we && (wr.addr == rd_addr));
			end
		end
	end

	// an entry never written since the last clear reads as zero
	assign rd_data = fwd_hit_q ? fwd_q : (vld_rd_q ? mem_rd_q : '0);

endmodule

// ===== design/channel_histogram_chart.sv =====
// Histogram and bar chart of one 8-bit pixel channel. Every command (clear, accumulate,
// render) is taken at one transaction per clock while the result side keeps up. The bins sit
// in a 256-entry synchronous RAM; the read issued at acceptance returns in the next cycle, the
// increment is written in that cycle, and a write that lands on the edge of a following read
// of the same bin is forwarded, so accumulates to one bin may follow back to back. A clear
// resets all per-bin valid flags together; there is no clearing sweep. A render result
// passes the RAM read, then the registered cross-multiply against the peak, then the output
// register, and a waiting result holds the pipeline only once both internal stages are full.
// channel_select may be written only while the block is idle.
module channel_histogram_chart import chc_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	chc_cfg_if.sink   cfg,
	chc_req_if.sink   req,
	chc_rsp_if.source rsp
);

	sel_t sel_q;

	logic   s1_v_q;
	cmd_t   cmd_s1;
	bin_t   bin_s1;
	row_t   row_s1;

	count_t peak_q;

	logic   s2_v_q;
	prod_t  lhs_s2;
	prod_t  rhs_s2;
	logic   above_s2;
	logic   nz_s2;
	logic   grid_s2;
	count_t cnt_s2;

	logic                   out_v_q;
	color_t                 color_q;
	logic [OUT_COUNT_W-1:0] count_q;

	logic      accept;
	bin_t      rd_addr;
	count_t    cur_cnt;
	count_t    inc_cnt;
	store_wr_t wr;
	logic      out_free;
	logic      s2_free;
	logic      s1_go;
	logic      s2_load;
	hgt_t      row_x;
	hgt_t      row_diff;
	logic      bar;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sel_q <= CH_RED;
		else if (cfg.valid)
			sel_q <= cfg.channel_select;
	end

	assign out_free  = !out_v_q || rsp.ready;
	assign s2_free   = !s2_v_q || out_free;
	assign s1_go     = s1_v_q && ((cmd_s1 != CMD_RENDER) || s2_free);
	assign s2_load   = s1_go && (cmd_s1 == CMD_RENDER);
	assign req.ready = !s1_v_q || s1_go;
	assign accept    = req.valid && req.ready;

	assign rd_addr = (req.cmd == CMD_ACCUM) ? channel_bin(req.pixel_word, sel_q) : req.column;

	chc_bin_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.wr      (wr),
		.rd_data (cur_cnt)
	);

	// saturating increment
	assign inc_cnt = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + count_t'(1);

	always_comb begin
		wr.we   = s1_go && (cmd_s1 == CMD_ACCUM);
		wr.clr  = s1_go && (cmd_s1 == CMD_CLEAR);
		wr.addr = bin_s1;
		wr.data = inc_cnt;
	end

	// stage 1: command after the RAM read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			peak_q <= '0;
		end else begin
			if (accept)
				s1_v_q <= 1'b1;
			else if (s1_go)
				s1_v_q <= 1'b0;
			if (wr.clr)
				peak_q <= '0;
			else if (wr.we && (inc_cnt > peak_q))
				peak_q <= inc_cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= req.cmd;
			bin_s1 <= rd_addr;
			row_s1 <= req.row;
		end
	end

	assign row_x    = CMP_W'(row_s1);
	assign row_diff = HGT_VAL - row_x;

	// stage 2: cross-multiply products for the bar test
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s2_v_q <= 1'b0;
		else if (s2_load)
			s2_v_q <= 1'b1;
		else if (out_free)
			s2_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s2_load) begin
			lhs_s2   <= PROD_W'(cur_cnt) * PROD_W'(HGT_VAL);
			rhs_s2   <= PROD_W'(row_diff) * PROD_W'(peak_q);
			above_s2 <= row_x >= HGT_VAL;
			nz_s2    <= peak_q != '0;
			grid_s2  <= grid_row(row_s1) && !bin_s1[0];
			cnt_s2   <= cur_cnt;
		end
	end

	// rows at or below the chart base make the right side non-positive
	assign bar = nz_s2 && (above_s2 || (lhs_s2 >= rhs_s2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (out_free)
			out_v_q <= s2_v_q;
	end

	always_ff @(posedge clk) begin
		if (out_free && s2_v_q) begin
			color_q <= bar ? bar_color(sel_q) : (grid_s2 ? COLOR_GRID : COLOR_BACK);
			count_q <= OUT_COUNT_W'(cnt_s2);
		end
	end

	assign rsp.valid        = out_v_q;
	assign rsp.chart_color  = color_q;
	assign rsp.column_count = count_q;

endmodule

// ===== design/chc_checker.sv =====
`include "assert_macros.svh"

module chc_checker import chc_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   req_valid,
	input logic                   req_ready,
	input logic                   rsp_valid,
	input logic                   rsp_ready,
	input color_t                 chart_color,
	input logic [OUT_COUNT_W-1:0] column_count
);

	logic rsp_stall;
	logic color_ok;

	assign rsp_stall = rsp_valid && !rsp_ready;
	assign color_ok  = (chart_color == COLOR_RED) || (chart_color == COLOR_GREEN) ||
		(chart_color == COLOR_BLUE) || (chart_color == COLOR_GRID) ||
		(chart_color == COLOR_BACK);

	`CHC_CHECK(a_rsp_hold, rsp_stall |=> rsp_valid)
	`CHC_CHECK(a_rsp_stable, rsp_stall |=> $stable(chart_color) && $stable(column_count))
	`CHC_CHECK(a_color_legal, rsp_valid |-> color_ok)
	`CHC_CHECK(a_backpressure_src, !req_ready |-> rsp_stall)

endmodule

bind channel_histogram_chart chc_checker u_chc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.chart_color  (rsp.chart_color),
	.column_count (rsp.column_count)
);
